// File: rtl/core/xmsau_pkg.sv
// Shared types, codes and a helper function for the segment address unit.
package xmsau_pkg;

   typedef enum logic [1:0] {
      CMD_WRITE_GPR  = 2'd0,
      CMD_WRITE_SEL  = 2'd1,
      CMD_WRITE_DESC = 2'd2,
      CMD_COMPUTE    = 2'd3
   } cmd_type;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_LIMIT = 2'd1;
   localparam logic [1:0] STATUS_SIB   = 2'd2;

   localparam logic CSR_PROTECTED = 1'b0;
   localparam logic CSR_LIMIT     = 1'b1;

   localparam logic [2:0] SEG_ES = 3'd0;
   localparam logic [2:0] SEG_CS = 3'd1;
   localparam logic [2:0] SEG_SS = 3'd2;
   localparam logic [2:0] SEG_DS = 3'd3;
   localparam logic [2:0] SEG_FS = 3'd4;
   localparam logic [2:0] SEG_GS = 3'd5;
   localparam int unsigned SEG_COUNT = 6;

   localparam logic [2:0] GPR_BX = 3'd3;
   localparam logic [2:0] GPR_BP = 3'd5;
   localparam logic [2:0] GPR_SI = 3'd6;
   localparam logic [2:0] GPR_DI = 3'd7;

   localparam logic [1:0] MOD_NO_DISP = 2'd0;
   localparam logic [1:0] MOD_DISP8   = 2'd1;
   localparam logic [1:0] MOD_DISP32  = 2'd2;
   localparam logic [1:0] MOD_REG     = 2'd3;

   localparam logic [2:0] RM_SIB    = 3'd4;
   localparam logic [2:0] RM_DIRECT = 3'd5;
   localparam logic [2:0] RM_BP16   = 3'd6;

   // Decoded operand form handed to the offset stage.
   typedef struct packed {
      logic [1:0]  mode;
      logic [2:0]  rm;
      logic        addr32;
      logic [31:0] disp;
   } ea_ctl_type;

   typedef struct packed {
      logic [31:0] offset;
      logic [31:0] reg_value;
      logic        is_reg;
      logic        sib;
   } ea_res_type;

   // The base is scattered over three fields of the descriptor entry.
   function automatic logic [31:0] desc_base(input logic [63:0] entry);
      desc_base = {entry[63:56], entry[39:32], entry[31:16]};
   endfunction

endpackage

// File: rtl/core/xmsau_gpr_file.sv
// General register file: one write port, two registered read ports, zero after reset.
module xmsau_gpr_file (
   input  logic        clock,
   input  logic        reset,
   input  logic        wr_en,
   input  logic [2:0]  wr_addr,
   input  logic [31:0] wr_data,
   input  logic        rd_en,
   input  logic [2:0]  rd_addr_a,
   input  logic [2:0]  rd_addr_b,
   output logic [31:0] rd_data_a,
   output logic [31:0] rd_data_b
);

   logic [31:0] mem [8];
   logic [7:0]  valid_ff;
   logic [7:0]  valid_in;
   logic [31:0] rd_a_ff;
   logic [31:0] rd_b_ff;
   logic        rd_valid_a_ff;
   logic        rd_valid_b_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff       <= mem[rd_addr_a];
         rd_b_ff       <= mem[rd_addr_b];
         rd_valid_a_ff <= valid_ff[rd_addr_a];
         rd_valid_b_ff <= valid_ff[rd_addr_b];
      end
   end

   // An entry never written since reset reads as zero.
   assign rd_data_a = rd_valid_a_ff ? rd_a_ff : '0;
   assign rd_data_b = rd_valid_b_ff ? rd_b_ff : '0;

endmodule

// File: rtl/core/xmsau_desc_table.sv
// Descriptor table memory with one write port and one registered read port.
module xmsau_desc_table #(
   parameter int unsigned DEPTH  = 256,
   parameter int unsigned ADDR_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [63:0]       wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [63:0]       rd_data
);

   logic [63:0] mem [DEPTH];
   logic [63:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/xmsau_offset.sv
// Offset computation for the 16-bit and 32-bit modrm forms and register operands.
module xmsau_offset (
   input  xmsau_pkg::ea_ctl_type ctl,
   input  logic [31:0]           gpr_a,
   input  logic [31:0]           gpr_b,
   output xmsau_pkg::ea_res_type res
);

   logic [31:0] disp8;
   logic [31:0] add32;
   logic [15:0] base16;
   logic [15:0] index16;
   logic [15:0] add16;

   always_comb begin
      disp8 = {{24{ctl.disp[7]}}, ctl.disp[7:0]};

      if (ctl.mode == xmsau_pkg::MOD_DISP8) begin
         add32 = disp8;
      end else if (ctl.mode == xmsau_pkg::MOD_DISP32) begin
         add32 = ctl.disp;
      end else begin
         add32 = '0;
      end

      // Mod zero with rm six is the direct 16-bit form: no base register.
      if (ctl.rm == xmsau_pkg::RM_BP16 && ctl.mode == xmsau_pkg::MOD_NO_DISP) begin
         base16 = '0;
      end else begin
         base16 = gpr_a[15:0];
      end
      index16 = (ctl.rm[2] == 1'b0) ? gpr_b[15:0] : '0;
      if (ctl.mode == xmsau_pkg::MOD_DISP8) begin
         add16 = disp8[15:0];
      end else if (ctl.mode == xmsau_pkg::MOD_DISP32 || ctl.rm == xmsau_pkg::RM_BP16) begin
         add16 = ctl.disp[15:0];
      end else begin
         add16 = '0;
      end

      res.is_reg    = (ctl.mode == xmsau_pkg::MOD_REG);
      res.reg_value = ctl.addr32 ? gpr_a : {16'd0, gpr_a[15:0]};
      res.sib       = ctl.addr32 && ctl.rm == xmsau_pkg::RM_SIB;
      if (ctl.addr32) begin
         if (ctl.mode == xmsau_pkg::MOD_NO_DISP && ctl.rm == xmsau_pkg::RM_DIRECT) begin
            res.offset = ctl.disp;
         end else begin
            res.offset = gpr_a + add32;
         end
      end else begin
         res.offset = {16'd0, 16'(base16 + index16 + add16)};
      end
   end

endmodule

// File: rtl/core/x86_modrm_segment_address_unit_top.sv
// Compute words read the register file and descriptor table, form the offset in
// ST_ADDR and the linear address in ST_LIN; write words go straight to ST_LIN. The
// response loads in ST_LIN once the output register is free or being taken. A new
// word is taken only after that, also while that response waits for rsp_ready.
// Reset clears control, configuration, general registers and selectors to zero;
// the descriptor table is undefined until written and gets no clearing pass.
module x86_modrm_segment_address_unit_top #(
   parameter int unsigned TABLE_ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_target_index,
   input  logic [63:0] req_write_value,
   input  logic [7:0]  req_prefix_bits,
   input  logic [7:0]  req_modrm_byte,
   input  logic [31:0] req_displacement,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_result_value,
   output logic        rsp_is_register,
   output logic [1:0]  rsp_status,
   input  logic        csr_write_enable,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [13:0] ENTRY_COUNT = 14'(TABLE_ENTRIES);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_ADDR = 3'b010,
      ST_LIN  = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic        prot_ff, prot_in;
   logic [15:0] limit_ff, limit_in;
   logic [15:0] seg_ff [xmsau_pkg::SEG_COUNT];
   logic [15:0] seg_pick;
   logic [15:0] sel_ff;
   logic        write_ff;
   xmsau_pkg::ea_ctl_type ctl_ff;
   xmsau_pkg::ea_res_type res;
   xmsau_pkg::ea_res_type res_ff;

   logic        accept;
   logic        is_compute;
   logic        gpr_wr_en;
   logic        desc_wr_en;
   logic        desc_rd_en;
   logic [2:0]  rd_addr_a;
   logic [2:0]  rd_addr_b;
   logic [31:0] gpr_a;
   logic [31:0] gpr_b;
   logic [63:0] desc_entry;
   logic [1:0]  req_mod;
   logic [2:0]  req_rm;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_value_ff;
   logic        rsp_is_reg_ff;
   logic [1:0]  rsp_status_ff;
   logic        rsp_load;
   logic [31:0] lin_value;
   logic [1:0]  lin_status;
   logic        sel_fail;

   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign is_compute = (req_command == xmsau_pkg::CMD_COMPUTE);
   assign req_mod    = req_modrm_byte[7:6];
   assign req_rm     = req_modrm_byte[2:0];

   assign gpr_wr_en  = accept && req_command == xmsau_pkg::CMD_WRITE_GPR &&
                       req_target_index < 8'd8;
   assign desc_wr_en = accept && req_command == xmsau_pkg::CMD_WRITE_DESC &&
                       {6'd0, req_target_index} < ENTRY_COUNT;
   assign desc_rd_en = accept && is_compute;

   // Last override in priority order wins; ds is the default segment.
   always_comb begin
      seg_pick = seg_ff[xmsau_pkg::SEG_DS];
      if (req_prefix_bits[4]) seg_pick = seg_ff[xmsau_pkg::SEG_ES];
      if (req_prefix_bits[3]) seg_pick = seg_ff[xmsau_pkg::SEG_DS];
      if (req_prefix_bits[2]) seg_pick = seg_ff[xmsau_pkg::SEG_CS];
      if (req_prefix_bits[5]) seg_pick = seg_ff[xmsau_pkg::SEG_SS];
      if (req_prefix_bits[6]) seg_pick = seg_ff[xmsau_pkg::SEG_FS];
      if (req_prefix_bits[7]) seg_pick = seg_ff[xmsau_pkg::SEG_GS];
   end

   // Register file read addresses; the 16-bit form reads a base and an index.
   always_comb begin
      if (req_mod == xmsau_pkg::MOD_REG || req_prefix_bits[1]) begin
         rd_addr_a = req_rm;
      end else begin
         case (req_rm)
            3'd0, 3'd1, 3'd7: rd_addr_a = xmsau_pkg::GPR_BX;
            3'd2, 3'd3, 3'd6: rd_addr_a = xmsau_pkg::GPR_BP;
            3'd4:             rd_addr_a = xmsau_pkg::GPR_SI;
            default:          rd_addr_a = xmsau_pkg::GPR_DI;
         endcase
      end
      rd_addr_b = req_rm[0] ? xmsau_pkg::GPR_DI : xmsau_pkg::GPR_SI;
   end

   xmsau_gpr_file u_gpr (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (gpr_wr_en),
      .wr_addr   (req_target_index[2:0]),
      .wr_data   (req_write_value[31:0]),
      .rd_en     (desc_rd_en),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (gpr_a),
      .rd_data_b (gpr_b)
   );

   xmsau_desc_table #(
      .DEPTH  (TABLE_ENTRIES),
      .ADDR_W (IDX_W)
   ) u_desc (
      .clock   (clock),
      .wr_en   (desc_wr_en),
      .wr_addr (IDX_W'(req_target_index)),
      .wr_data (req_write_value),
      .rd_en   (desc_rd_en),
      .rd_addr (IDX_W'(seg_pick[15:3])),
      .rd_data (desc_entry)
   );

   xmsau_offset u_offset (
      .ctl   (ctl_ff),
      .gpr_a (gpr_a),
      .gpr_b (gpr_b),
      .res   (res)
   );

   always_ff @(posedge clock) begin
      if (accept) begin
         ctl_ff.mode   <= req_mod;
         ctl_ff.rm     <= req_rm;
         ctl_ff.addr32 <= req_prefix_bits[1];
         ctl_ff.disp   <= req_displacement;
         sel_ff        <= seg_pick;
      end
      if (state_ff == ST_ADDR) begin
         res_ff <= res;
      end
   end

   // Final address and status from the offset and the selected segment.
   always_comb begin
      sel_fail = (sel_ff > limit_ff) || !({1'b0, sel_ff[15:3]} < ENTRY_COUNT);
      lin_status = xmsau_pkg::STATUS_OK;
      if (write_ff) begin
         lin_value = '0;
      end else if (res_ff.is_reg) begin
         lin_value = res_ff.reg_value;
      end else if (res_ff.sib) begin
         lin_value  = '0;
         lin_status = xmsau_pkg::STATUS_SIB;
      end else if (!prot_ff) begin
         lin_value = {12'd0, sel_ff, 4'd0} + res_ff.offset;
      end else if (sel_fail) begin
         lin_value  = '0;
         lin_status = xmsau_pkg::STATUS_LIMIT;
      end else begin
         lin_value = xmsau_pkg::desc_base(desc_entry) + res_ff.offset;
      end
   end

   assign rsp_load = (state_ff == ST_LIN) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = is_compute ? ST_ADDR : ST_LIN;
            end
         end
         ST_ADDR: state_in = ST_LIN;
         ST_LIN: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      prot_in  = prot_ff;
      limit_in = limit_ff;
      if (csr_write_enable) begin
         case (csr_index)
            xmsau_pkg::CSR_PROTECTED: prot_in  = csr_write_data[0];
            xmsau_pkg::CSR_LIMIT:     limit_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         prot_ff      <= 1'b0;
         limit_ff     <= '0;
         write_ff     <= 1'b0;
         for (int i = 0; i < xmsau_pkg::SEG_COUNT; i++) begin
            seg_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         prot_ff      <= prot_in;
         limit_ff     <= limit_in;
         if (accept) begin
            write_ff <= !is_compute;
         end
         if (accept && req_command == xmsau_pkg::CMD_WRITE_SEL &&
             req_target_index < 8'(xmsau_pkg::SEG_COUNT)) begin
            seg_ff[req_target_index[2:0]] <= req_write_value[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_value_ff  <= lin_value;
         rsp_is_reg_ff <= !write_ff && res_ff.is_reg;
         rsp_status_ff <= lin_status;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_is_register  = rsp_is_reg_ff;
   assign rsp_status       = rsp_status_ff;

endmodule
